// ===== src/swsfd_pkg.sv =====
// Shared types and constants of the single-wire sensor frame decoder.
package swsfd_pkg;

  localparam int TimeWidth = 63;
  localparam int WordWidth = 40;
  localparam int EdgeWidth = 6;
  localparam int ThrWidth = 20;
  localparam int ThrUsWidth = 11;
  localparam int ThrNsWidth = 21;
  localparam int AddrWidth = 3;

  // Edge 0 is the start item; edges before FirstDataEdge only set the reference.
  localparam logic [EdgeWidth-1:0] FirstDataEdge = 6'd2;
  localparam logic [EdgeWidth-1:0] TotalEdges = 6'd42;

  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_EDGE = 2'd1;
  localparam logic [1:0] ACT_TIMEOUT = 2'd2;

  localparam logic [1:0] ST_GOOD = 2'd0;
  localparam logic [1:0] ST_CHECKSUM = 2'd1;
  localparam logic [1:0] ST_TIMEOUT = 2'd2;

  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_INVALID = 1'b1;

  localparam logic [ThrWidth-1:0] ThresholdReset = 20'd100000;
  localparam logic [7:0] InvalidReset = 8'd255;
  // ceil(100000 / 1000)
  localparam logic [ThrUsWidth-1:0] ThrUsReset = 11'd100;

  typedef struct packed {
    logic [1:0]           action;
    logic [TimeWidth-1:0] time_ns;
  } item_t;

  typedef struct packed {
    logic [7:0] humidity;
    logic [7:0] temperature;
    logic [1:0] status;
  } result_t;

  typedef struct packed {
    logic [ThrUsWidth-1:0] thr_us;   // threshold rounded up to whole microseconds
    logic [7:0]            invalid_value;
  } cfg_t;

endpackage

// ===== src/swsfd_regs.sv =====
// Configuration registers with APB-style access and threshold rounding.
module swsfd_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [swsfd_pkg::AddrWidth-1:0]   paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  output swsfd_pkg::cfg_t                   cfg
);

  logic [swsfd_pkg::ThrWidth-1:0]   one_threshold_ns;
  logic [7:0]                       invalid_value;
  logic [swsfd_pkg::ThrUsWidth-1:0] thr_us;

  logic        wr_en;
  logic [20:0] thr_up;
  logic [17:0] thr_div8;
  logic [35:0] thr_prod;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite && pready;

  // ceil(x / 1000) = floor((x + 999) / 8 / 125); the divide by 125 is a
  // reciprocal multiply, exact for the 18-bit range used here.
  assign thr_up = {1'b0, pwdata[swsfd_pkg::ThrWidth-1:0]} + 21'd999;
  assign thr_div8 = thr_up[20:3];
  assign thr_prod = {18'd0, thr_div8} * 36'd134218;

  always_ff @(posedge clk) begin
    if (rst) begin
      one_threshold_ns <= swsfd_pkg::ThresholdReset;
      invalid_value <= swsfd_pkg::InvalidReset;
      thr_us <= swsfd_pkg::ThrUsReset;
    end else if (wr_en) begin
      unique case (paddr[2])
        swsfd_pkg::REG_THRESHOLD: begin
          one_threshold_ns <= pwdata[swsfd_pkg::ThrWidth-1:0];
          thr_us <= thr_prod[34:24];
        end
        swsfd_pkg::REG_INVALID: begin
          invalid_value <= pwdata[7:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      swsfd_pkg::REG_THRESHOLD: prdata = {12'd0, one_threshold_ns};
      swsfd_pkg::REG_INVALID:   prdata = {24'd0, invalid_value};
      default:                  prdata = 32'd0;
    endcase
  end

  assign cfg.thr_us = thr_us;
  assign cfg.invalid_value = invalid_value;

endmodule

// ===== src/single_wire_sensor_frame_decoder.sv =====
// Top level: single-wire sensor frame decoder, input register, decode and result register.
//
//   channel   direction  handshake                   payload
//   item      in         item_valid / item_stall     swsfd_pkg::item_t
//   result    out        result_valid / result_stall swsfd_pkg::result_t
//   config    in         APB psel / penable / pready 32-bit registers at 0x0, 0x4
//
// One item per cycle unless a stalled result holds the pipeline; each item passes the
// input register and then the result register, and the interval
// subtract, threshold compare and checksum add fit between them.
// rst is synchronous and clears the capture state and both pipeline valids.
// A stalled result holds the decode stage; the input register still takes one item.
module single_wire_sensor_frame_decoder (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  swsfd_pkg::item_t                item,
  output logic                            result_valid,
  input  logic                            result_stall,
  output swsfd_pkg::result_t              result,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [swsfd_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  swsfd_pkg::cfg_t cfg;

  swsfd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // input register
  logic             s1_valid;
  swsfd_pkg::item_t s1_item;

  // capture state
  logic                              capturing;
  logic                              capturing_next;
  logic [swsfd_pkg::EdgeWidth-1:0]   edge_count;
  logic [swsfd_pkg::EdgeWidth-1:0]   edge_count_next;
  logic [swsfd_pkg::TimeWidth-1:0]   previous_time;
  logic [swsfd_pkg::TimeWidth-1:0]   previous_time_next;
  logic [swsfd_pkg::WordWidth-1:0]   bit_word;
  logic [swsfd_pkg::WordWidth-1:0]   bit_word_next;

  logic                              advance;
  logic                              fire;
  swsfd_pkg::result_t                res;

  logic [swsfd_pkg::ThrNsWidth-1:0]  thr_ns;
  logic [swsfd_pkg::TimeWidth-1:0]   diff;
  logic                              data_bit;
  logic [swsfd_pkg::WordWidth-1:0]   shifted;
  logic [8:0]                        check_sum;

  assign advance = !(result_valid && result_stall);
  assign item_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!item_stall) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall) begin
      s1_item <= item;
    end
  end

  // q * 1000 as shifts: q * (1024 - 16 - 8)
  assign thr_ns = {cfg.thr_us, 10'd0} - {6'd0, cfg.thr_us, 4'd0} - {7'd0, cfg.thr_us, 3'd0};

  // floor(d / 1000) * 1000 >= thr  <=>  d >= 1000 * ceil(thr / 1000)
  assign diff = (s1_item.time_ns >= previous_time) ? (s1_item.time_ns - previous_time)
                                                   : '0;
  assign data_bit = (diff >= {{(swsfd_pkg::TimeWidth - swsfd_pkg::ThrNsWidth){1'b0}}, thr_ns});
  assign shifted = {bit_word[swsfd_pkg::WordWidth-2:0], data_bit};

  always_comb begin
    capturing_next = capturing;
    edge_count_next = edge_count;
    previous_time_next = previous_time;
    bit_word_next = bit_word;
    fire = 1'b0;
    res = '{humidity: cfg.invalid_value, temperature: cfg.invalid_value,
            status: swsfd_pkg::ST_TIMEOUT};
    check_sum = '0;
    unique case (s1_item.action)
      swsfd_pkg::ACT_START: begin
        capturing_next = 1'b1;
        edge_count_next = 6'd1;
        previous_time_next = s1_item.time_ns;
        bit_word_next = '0;
      end
      swsfd_pkg::ACT_TIMEOUT: begin
        if (capturing) begin
          capturing_next = 1'b0;
          edge_count_next = '0;
          fire = 1'b1;
        end
      end
      swsfd_pkg::ACT_EDGE: begin
        if (capturing) begin
          edge_count_next = edge_count + 6'd1;
          previous_time_next = s1_item.time_ns;
          if (edge_count >= swsfd_pkg::FirstDataEdge) begin
            bit_word_next = shifted;
          end
          if (edge_count >= swsfd_pkg::TotalEdges - 6'd1) begin
            capturing_next = 1'b0;
            edge_count_next = '0;
            fire = 1'b1;
            check_sum = {1'b0, bit_word_next[39:32]} + {1'b0, bit_word_next[23:16]};
            if (check_sum == {1'b0, bit_word_next[7:0]}) begin
              res = '{humidity: bit_word_next[39:32], temperature: bit_word_next[23:16],
                      status: swsfd_pkg::ST_GOOD};
            end else begin
              res.status = swsfd_pkg::ST_CHECKSUM;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capturing <= 1'b0;
      edge_count <= '0;
      previous_time <= '0;
      bit_word <= '0;
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= s1_valid && fire;
      if (s1_valid) begin
        capturing <= capturing_next;
        edge_count <= edge_count_next;
        previous_time <= previous_time_next;
        bit_word <= bit_word_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= res;
    end
  end

endmodule
